>>> hw/rtl/ttc_pkg.sv
// Shared types, constants and score helpers for the clustered transposition table.
// Used by every module under hw/rtl except ttc_ram; depends on nothing.
package ttc_pkg;

  // Table geometry: four-way clusters, one cluster per memory row
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned SLOTS_PER_ROW = 4;
  localparam int unsigned ROWS          = TABLE_ENTRIES / SLOTS_PER_ROW;
  localparam int unsigned ROW_AW        = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int unsigned MATE_MARGIN = 200;
  localparam int unsigned SLOT1_SLACK = 8;

  // Configuration register map (word index)
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_MATE_VALUE = 2'd0;
  localparam logic [1:0] REG_MISS_TYPE  = 2'd1;
  localparam logic [1:0] REG_MISS_SCORE = 2'd2;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_PROBE = 1'b1;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [7:0]         btype;
    logic [5:0]         mfrom;
    logic [5:0]         mto;
    logic [6:0]         mkind;
  } entry_t;

  typedef entry_t [SLOTS_PER_ROW-1:0] row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef struct packed {
    logic [14:0]        mate_value;
    logic [7:0]         miss_type;
    logic signed [15:0] miss_score;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic [63:0]        key;
    logic [7:0]         depth;
    logic [6:0]         ply;
    logic signed [15:0] score;
    logic [7:0]         btype;
    logic [5:0]         mfrom;
    logic [5:0]         mto;
    logic [6:0]         mkind;
  } req_t;

  typedef struct packed {
    logic [7:0]         depth;
    logic [7:0]         btype;
    logic [5:0]         mfrom;
    logic [5:0]         mto;
    logic [6:0]         mkind;
    logic signed [15:0] score;
    logic               cutoff;
  } res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  // Magnitude beyond mate_value - margin marks a mate score
  function automatic logic is_mate(logic signed [15:0] s, logic [14:0] mv);
    logic signed [16:0] mag;
    logic signed [16:0] thr;
    mag = s[15] ? (17'sd0 - 17'(s)) : 17'(s);
    thr = $signed({2'b00, mv}) - 17'(MATE_MARGIN);
    return mag > thr;
  endfunction

  // Row of the cluster that a key selects
  function automatic logic [ROW_AW-1:0] key_row(logic [63:0] key);
    return ROW_AW'((key >> 2) & 64'(ROWS - 1));
  endfunction

endpackage

>>> hw/rtl/transposition_table_cluster_top.sv
// Clustered transposition table: one cluster of four entries per RAM row, read then written back.
// Probe: row read on accept; result word registered in ST_EVAL once the output has room.
// Store: row read on accept, written back in ST_EVAL; no new word meanwhile (single RAM port).
// Reset: a clearing pass writes TABLE_ENTRIES/4 zero rows, input stalled meanwhile.
// Configuration writes are taken at any time. Depends on ttc_pkg, ttc_ram, ttc_cfg, ttc_eval.
module transposition_table_cluster_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ttc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [63:0]                position_key_i,
  input  logic [7:0]                 search_depth_i,
  input  logic [6:0]                 ply_from_root_i,
  input  logic signed [15:0]         score_i,
  input  logic [7:0]                 bound_type_i,
  input  logic [5:0]                 move_from_i,
  input  logic [5:0]                 move_to_i,
  input  logic [6:0]                 move_kind_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 found_depth_o,
  output logic [7:0]                 found_type_o,
  output logic [5:0]                 found_from_o,
  output logic [5:0]                 found_to_o,
  output logic [6:0]                 found_kind_o,
  output logic signed [15:0]         found_score_o,
  output logic                       cutoff_o
);
  import ttc_pkg::*;

  cfg_t cfg;

  ttc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e            state_q, state_d;
  logic [ROW_AW-1:0] clr_q, clr_d;
  req_t              req_q, req_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  logic              ram_en, ram_we;
  logic [ROW_AW-1:0] ram_addr;
  row_t              ram_wdata, ram_rdata, wr_row;
  res_t              eval_res;
  logic              in_acc, out_free;

  ttc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS),
    .AW    (ROW_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  ttc_eval u_eval (
    .row_i    (ram_rdata),
    .req_i    (req_q),
    .cfg_i    (cfg),
    .wr_row_o (wr_row),
    .res_o    (eval_res)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // sequencer: clear sweep, accept and read, then write back a store or answer a probe
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = key_row(req_q.key);
    ram_wdata   = wr_row;
    case (state_q)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ROW_AW'(1);
        if (clr_q == ROW_AW'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          ram_en      = 1'b1;
          ram_addr    = key_row(position_key_i);
          req_d.func  = func_i;
          req_d.key   = position_key_i;
          req_d.depth = search_depth_i;
          req_d.ply   = ply_from_root_i;
          req_d.score = score_i;
          req_d.btype = bound_type_i;
          req_d.mfrom = move_from_i;
          req_d.mto   = move_to_i;
          req_d.mkind = move_kind_i;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (req_q.func == FUNC_STORE) begin
          ram_en  = 1'b1;
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end else if (out_free) begin
          // read data holds in the RAM while the result waits for space
          res_d       = eval_res;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_depth_o = res_q.depth;
  assign found_type_o  = res_q.btype;
  assign found_from_o  = res_q.mfrom;
  assign found_to_o    = res_q.mto;
  assign found_kind_o  = res_q.mkind;
  assign found_score_o = res_q.score;
  assign cutoff_o      = res_q.cutoff;

endmodule

>>> hw/rtl/ttc_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Stand-alone; read data holds until the next read.
module ttc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ttc_cfg.sv
// APB-style configuration registers: mate value, miss type, miss score.
// Depends on ttc_pkg.
module ttc_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ttc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output ttc_pkg::cfg_t             cfg_o
);
  import ttc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MATE_VALUE: cfg_d.mate_value = pwdata[14:0];
        REG_MISS_TYPE:  cfg_d.miss_type  = pwdata[7:0];
        REG_MISS_SCORE: cfg_d.miss_score = $signed(pwdata[15:0]);
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mate_value <= 15'd32000;
      cfg_q.miss_type  <= 8'd0;
      cfg_q.miss_score <= 16'sd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_MATE_VALUE: prdata = {17'd0, cfg_q.mate_value};
      REG_MISS_TYPE:  prdata = {24'd0, cfg_q.miss_type};
      REG_MISS_SCORE: prdata = {{16{cfg_q.miss_score[15]}}, cfg_q.miss_score};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/ttc_eval.sv
// Cluster evaluation: replacement choice and new row for store, deepest-hit scan for probe.
// Depends on ttc_pkg; purely combinational on the row read back from the table.
module ttc_eval (
  input  ttc_pkg::row_t  row_i,
  input  ttc_pkg::req_t  req_i,
  input  ttc_pkg::cfg_t  cfg_i,
  output ttc_pkg::row_t  wr_row_o,
  output ttc_pkg::res_t  res_o
);
  import ttc_pkg::*;

  logic [1:0] base_lo;
  assign base_lo = req_i.key[1:0];

  // slot k sits in lane base_lo ^ k
  entry_t s0, s1, s2, s3;
  assign s0 = row_i[base_lo ^ 2'd0];
  assign s1 = row_i[base_lo ^ 2'd1];
  assign s2 = row_i[base_lo ^ 2'd2];
  assign s3 = row_i[base_lo ^ 2'd3];

  // store: ply-adjust mate scores and saturate
  logic signed [16:0] st_adj;
  logic signed [15:0] st_score;
  always_comb begin
    logic signed [16:0] s17;
    logic signed [16:0] p17;
    s17 = 17'(req_i.score);
    p17 = $signed({10'd0, req_i.ply});
    if (is_mate(req_i.score, cfg_i.mate_value)) begin
      st_adj = (req_i.score > 16'sd0) ? (s17 + p17) : (s17 - p17);
    end else begin
      st_adj = s17;
    end
    if (st_adj > 17'sd32767) begin
      st_score = 16'sh7fff;
    end else if (st_adj < -17'sd32768) begin
      st_score = 16'sh8000;
    end else begin
      st_score = st_adj[15:0];
    end
  end

  // replacement test, kept in its original order
  logic [1:0] dst_slot;
  always_comb begin
    if (s0.key != req_i.key || req_i.depth >= s0.depth) begin
      dst_slot = 2'd0;
    end else if (s1.key != req_i.key ||
                 ({1'b0, req_i.depth} + 9'(SLOT1_SLACK)) >= {1'b0, s1.depth}) begin
      dst_slot = 2'd1;
    end else if (s2.key != req_i.key || s2.depth <= s3.depth) begin
      dst_slot = 2'd2;
    end else begin
      dst_slot = 2'd3;
    end
  end

  entry_t new_entry;
  always_comb begin
    new_entry.key   = req_i.key;
    new_entry.score = st_score;
    new_entry.depth = req_i.depth;
    new_entry.btype = req_i.btype;
    new_entry.mfrom = req_i.mfrom;
    new_entry.mto   = req_i.mto;
    new_entry.mkind = req_i.mkind;
    wr_row_o = row_i;
    wr_row_o[base_lo ^ dst_slot] = new_entry;
  end

  // probe: scan slot 3 down to slot 0, keep deepest hit, stop at cutoff
  logic       hit;
  logic       cut;
  logic [1:0] sel;
  always_comb begin
    logic [7:0] hdep;
    logic       done;
    logic [1:0] lane;
    hit  = 1'b0;
    cut  = 1'b0;
    sel  = 2'd0;
    hdep = 8'd0;
    done = 1'b0;
    for (int k = SLOTS_PER_ROW - 1; k >= 0; k--) begin
      lane = base_lo ^ 2'(k);
      if (!done && row_i[lane].key == req_i.key && row_i[lane].depth > hdep) begin
        hit  = 1'b1;
        sel  = lane;
        hdep = row_i[lane].depth;
        if (row_i[lane].depth >= req_i.depth) begin
          cut  = 1'b1;
          done = 1'b1;
        end
      end
    end
  end

  // probe result: undo mate adjustment, or miss defaults
  entry_t hit_e;
  assign hit_e = row_i[sel];

  always_comb begin
    logic signed [16:0] h17;
    logic signed [16:0] p17;
    logic signed [16:0] radj;
    h17 = 17'(hit_e.score);
    p17 = $signed({10'd0, req_i.ply});
    if (is_mate(hit_e.score, cfg_i.mate_value)) begin
      radj = (hit_e.score > 16'sd0) ? (h17 - p17) : (h17 + p17);
    end else begin
      radj = h17;
    end
    if (hit) begin
      res_o.depth = hit_e.depth;
      res_o.btype = hit_e.btype;
      res_o.mfrom = hit_e.mfrom;
      res_o.mto   = hit_e.mto;
      res_o.mkind = hit_e.mkind;
      res_o.score = radj[15:0];
    end else begin
      res_o.depth = 8'd0;
      res_o.btype = cfg_i.miss_type;
      res_o.mfrom = 6'd0;
      res_o.mto   = 6'd0;
      res_o.mkind = 7'd0;
      res_o.score = cfg_i.miss_score;
    end
    res_o.cutoff = cut;
  end

endmodule

>>> verif/tb_top.sv
// Self-checking bench for transposition_table_cluster_top: store and probe words against a
// shadow copy of the clustered table. Depends on ttc_pkg and the RTL under hw/rtl.

// Shadow table: tracks every slot and the miss/mate registers, queues the probe answers
class tt_cluster_model;
  ttc_pkg::entry_t    slots [ttc_pkg::TABLE_ENTRIES];
  logic [14:0]        mate_value;
  logic [7:0]         miss_type;
  logic signed [15:0] miss_score;
  ttc_pkg::res_t      awaited [$];
  int unsigned        mismatches;

  function void clear_all();
    foreach (slots[i]) slots[i] = '0;
    mate_value = 15'd32000;
    miss_type  = '0;
    miss_score = '0;
    awaited.delete();
    mismatches = 0;
  endfunction

  // Slot k of the cluster: base index XOR k, folded into the table
  function int unsigned slot_of(logic [63:0] key, int unsigned k);
    logic [63:0] base;
    base = key & 64'(ttc_pkg::TABLE_ENTRIES - 1);
    return 32'((base ^ 64'(k)) % 64'(ttc_pkg::TABLE_ENTRIES));
  endfunction

  function bit is_mate_score(int s);
    int mag;
    int thr;
    mag = (s < 0) ? -s : s;
    thr = int'(mate_value);
    thr = thr - int'(ttc_pkg::MATE_MARGIN);
    return mag > thr;
  endfunction

  // Store: mate shift away from zero, saturate, then the replacement choice
  function void store_entry(ttc_pkg::req_t r);
    int sc;
    int ply;
    int dep;
    int pick;
    int unsigned k;
    int unsigned a [4];
    sc  = int'($signed(r.score));
    ply = int'(r.ply);
    dep = int'(r.depth);
    if (is_mate_score(sc)) sc = (sc > 0) ? sc + ply : sc - ply;
    if (sc > 32767) sc = 32767;
    if (sc < -32768) sc = -32768;
    for (k = 0; k < 4; k++) a[k] = slot_of(r.key, k);
    if (slots[a[0]].key != r.key || dep >= int'(slots[a[0]].depth)) begin
      pick = 0;
    end else if (slots[a[1]].key != r.key ||
                 dep >= int'(slots[a[1]].depth) - int'(ttc_pkg::SLOT1_SLACK)) begin
      pick = 1;
    end else if (slots[a[2]].key != r.key || slots[a[2]].depth <= slots[a[3]].depth) begin
      pick = 2;
    end else begin
      pick = 3;
    end
    slots[a[pick]] = '{key: r.key, score: 16'(sc), depth: r.depth, btype: r.btype,
                       mfrom: r.mfrom, mto: r.mto, mkind: r.mkind};
  endfunction

  // Probe: scan slot 3 down to 0, keep deepest match, stop once deep enough
  function ttc_pkg::res_t probe_entry(ttc_pkg::req_t r);
    ttc_pkg::res_t   hit;
    ttc_pkg::entry_t e;
    int hdep;
    int hs;
    int ply;
    int k;
    bit cut;
    hit       = '0;
    hit.btype = miss_type;
    hs        = int'($signed(miss_score));
    hdep      = 0;
    cut       = 1'b0;
    ply       = int'(r.ply);
    for (k = 0; k < 4 && !cut; k++) begin
      e = slots[slot_of(r.key, 3 - k)];
      if (e.key == r.key && int'(e.depth) > hdep) begin
        hs = int'($signed(e.score));
        if (is_mate_score(hs)) hs = (hs > 0) ? hs - ply : hs + ply;
        hdep      = int'(e.depth);
        hit.btype = e.btype;
        hit.mfrom = e.mfrom;
        hit.mto   = e.mto;
        hit.mkind = e.mkind;
        if (hdep >= int'(r.depth)) cut = 1'b1;
      end
    end
    hit.depth  = 8'(hdep);
    hit.score  = 16'(hs);
    hit.cutoff = cut;
    return hit;
  endfunction

  // Accepted input word
  function void record_word(ttc_pkg::req_t r);
    if (r.func == ttc_pkg::FUNC_PROBE) awaited.push_back(probe_entry(r));
    else store_entry(r);
  endfunction

  // Accepted output word against the oldest pending answer
  function void check_word(ttc_pkg::res_t got);
    ttc_pkg::res_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected found word: depth=%0d type=%0d score=%0d cut=%0d",
                 got.depth, got.btype, $signed(got.score), got.cutoff);
      return;
    end
    want = awaited.pop_front();
    if (got.depth !== want.depth || got.btype !== want.btype || got.mfrom !== want.mfrom ||
        got.mto !== want.mto || got.mkind !== want.mkind || got.score !== want.score ||
        got.cutoff !== want.cutoff) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("probe mismatch exp: d=%0d t=%0d f=%0d to=%0d k=%0d s=%0d c=%0d",
                 want.depth, want.btype, want.mfrom, want.mto, want.mkind,
                 $signed(want.score), want.cutoff);
        $display("probe mismatch got: d=%0d t=%0d f=%0d to=%0d k=%0d s=%0d c=%0d",
                 got.depth, got.btype, got.mfrom, got.mto, got.mkind,
                 $signed(got.score), got.cutoff);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned POOL_SIZE      = 24;
  localparam int unsigned PHASE_WORDS    = 104;
  localparam int unsigned NUM_PHASES     = 8;

  logic                       clk_i;
  logic                       rst_ni          = 1'b0;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [ttc_pkg::CFG_AW-1:0] paddr           = '0;
  logic [31:0]                pwdata          = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic                       func_i          = 1'b0;
  logic [63:0]                position_key_i  = '0;
  logic [7:0]                 search_depth_i  = '0;
  logic [6:0]                 ply_from_root_i = '0;
  logic signed [15:0]         score_i         = '0;
  logic [7:0]                 bound_type_i    = '0;
  logic [5:0]                 move_from_i     = '0;
  logic [5:0]                 move_to_i       = '0;
  logic [6:0]                 move_kind_i     = '0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic [7:0]                 found_depth_o;
  logic [7:0]                 found_type_o;
  logic [5:0]                 found_from_o;
  logic [5:0]                 found_to_o;
  logic [6:0]                 found_kind_o;
  logic signed [15:0]         found_score_o;
  logic                       cutoff_o;

  tt_cluster_model shadow;
  ttc_pkg::res_t   seen_word;
  logic [63:0]     key_pool [POOL_SIZE];
  int unsigned     idle_pct    = 0;
  int unsigned     stall_pct   = 0;
  int unsigned     quiet_count = 0;

  transposition_table_cluster_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .position_key_i  (position_key_i),
    .search_depth_i  (search_depth_i),
    .ply_from_root_i (ply_from_root_i),
    .score_i         (score_i),
    .bound_type_i    (bound_type_i),
    .move_from_i     (move_from_i),
    .move_to_i       (move_to_i),
    .move_kind_i     (move_kind_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_depth_o   (found_depth_o),
    .found_type_o    (found_type_o),
    .found_from_o    (found_from_o),
    .found_to_o      (found_to_o),
    .found_kind_o    (found_kind_o),
    .found_score_o   (found_score_o),
    .cutoff_o        (cutoff_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Output monitor and watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_word = '{depth: found_depth_o, btype: found_type_o, mfrom: found_from_o,
                    mto: found_to_o, mkind: found_kind_o, score: found_score_o,
                    cutoff: cutoff_o};
      shadow.check_word(seen_word);
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
    end
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // One APB write; leaves psel/penable up so back-to-back writes stay glitch free
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
  endtask

  task automatic set_config(input logic [14:0] mv, input logic [7:0] mt,
                            input logic signed [15:0] ms);
    reg_write(ttc_pkg::REG_MATE_VALUE, 32'(mv));
    reg_write(ttc_pkg::REG_MISS_TYPE, 32'(mt));
    reg_write(ttc_pkg::REG_MISS_SCORE, 32'($unsigned(ms)));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.mate_value = mv;
    shadow.miss_type  = mt;
    shadow.miss_score = ms;
  endtask

  // Drive one input word, with random sender gaps, until accepted
  task automatic send_word(input ttc_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= r.func;
    position_key_i  <= r.key;
    search_depth_i  <= r.depth;
    ply_from_root_i <= r.ply;
    score_i         <= r.score;
    bound_type_i    <= r.btype;
    move_from_i     <= r.mfrom;
    move_to_i       <= r.mto;
    move_kind_i     <= r.mkind;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    shadow.record_word(r);
  endtask

  // Wait for all probe answers, then let a pending store land
  task automatic wait_drained();
    while (shadow.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic ttc_pkg::req_t build_req(input logic f, input logic [63:0] key,
                                              input logic [7:0] depth, input logic [6:0] ply,
                                              input logic signed [15:0] score);
    ttc_pkg::req_t r;
    r.func  = f;
    r.key   = key;
    r.depth = depth;
    r.ply   = ply;
    r.score = score;
    r.btype = 8'($urandom);
    r.mfrom = 6'($urandom);
    r.mto   = 6'($urandom);
    r.mkind = 7'($urandom);
    return r;
  endfunction

  // Scores clustered around the mate threshold, the mate value and the extremes, plus zero, small and random ones
  function automatic logic signed [15:0] pick_score();
    int mv;
    int s;
    mv = int'(shadow.mate_value);
    case ($urandom_range(7))
      0: s = int'($signed(16'($urandom)));
      1: s = mv - 200 + int'($urandom_range(4)) - 2;
      2: s = mv + int'($urandom_range(3));
      3: s = $urandom_range(1) ? 32767 : -32768;
      4: s = 0;
      5: s = int'($urandom_range(600)) - 300;
      default: s = mv - int'($urandom_range(199));
    endcase
    if ($urandom_range(1)) s = -s;
    return 16'(s);
  endfunction

  // Mostly pool keys so clusters fill and hit; some fully random keys as noise
  function automatic ttc_pkg::req_t random_req();
    logic [63:0] key;
    logic [7:0]  depth;
    logic        f;
    f     = ($urandom_range(99) < 50) ? ttc_pkg::FUNC_PROBE : ttc_pkg::FUNC_STORE;
    key   = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                      : {$urandom, $urandom};
    depth = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20));
    return build_req(f, key, depth, 7'($urandom), pick_score());
  endfunction

  initial begin
    logic [51:0]   tags [4];
    logic [9:0]    rows [6];
    ttc_pkg::req_t r;
    int unsigned   i;
    int unsigned   p;
    logic [63:0]   k1;
    logic [63:0]   k2;
    logic [63:0]   k3;
    logic [63:0]   k4;

    shadow = new();
    shadow.clear_all();

    tags[0] = '0;
    tags[1] = '1;
    tags[2] = 52'({$urandom, $urandom});
    tags[3] = 52'({$urandom, $urandom});
    rows[0] = '0;
    rows[1] = '1;
    for (i = 2; i < 6; i++) rows[i] = 10'($urandom);
    for (i = 0; i < POOL_SIZE; i++)
      key_pool[i] = {tags[$urandom_range(3)], rows[$urandom_range(5)], 2'($urandom)};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_config(15'd32000, 8'hA5, -16'sd1234);

    // Directed: empty table, cluster fill through all four slots, mate and saturation
    k1 = 64'h0123_4567_89AB_C004;
    k2 = 64'hFEDC_BA98_7654_3FFF;
    k3 = 64'h0000_0001_0000_0800;
    k4 = 64'h5555_AAAA_5555_0AA8;
    send_word(build_req(ttc_pkg::FUNC_PROBE, 64'h0, 8'd0, 7'd0, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k1, 8'd0, 7'd0, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_STORE, k1, 8'd50, 7'd3, 16'sd100));
    send_word(build_req(ttc_pkg::FUNC_STORE, k1, 8'd30, 7'd3, -16'sd50));
    send_word(build_req(ttc_pkg::FUNC_STORE, k1, 8'd10, 7'd3, 16'sd7));
    send_word(build_req(ttc_pkg::FUNC_STORE, k1, 8'd5, 7'd3, 16'sd8));
    send_word(build_req(ttc_pkg::FUNC_STORE, k1, 8'd7, 7'd3, 16'sd9));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k1, 8'd255, 7'd0, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k1, 8'd25, 7'd0, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k1, 8'd0, 7'd0, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k1 ^ 64'h1, 8'd0, 7'd0, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_STORE, k2, 8'd9, 7'd10, 16'sd31900));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k2, 8'd9, 7'd3, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_STORE, k2, 8'd12, 7'd127, -16'sd31850));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k2, 8'd1, 7'd0, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_STORE, k3, 8'd3, 7'd127, 16'sh7FFF));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k3, 8'd3, 7'd5, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_STORE, k3, 8'd4, 7'd127, 16'sh8000));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k3, 8'd4, 7'd127, 16'sd0));
    // threshold exactly vs one past it
    send_word(build_req(ttc_pkg::FUNC_STORE, k4, 8'd2, 7'd50, 16'sd31800));
    send_word(build_req(ttc_pkg::FUNC_STORE, k4 ^ 64'h2, 8'd2, 7'd50, -16'sd31801));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k4, 8'd2, 7'd20, 16'sd0));
    send_word(build_req(ttc_pkg::FUNC_PROBE, k4 ^ 64'h2, 8'd2, 7'd20, 16'sd0));
    // all-ones fields, then an all-zero store that must stay invisible
    r       = build_req(ttc_pkg::FUNC_STORE, '1, 8'd255, 7'd127, 16'sh7FFF);
    r.btype = '1;
    r.mfrom = '1;
    r.mto   = '1;
    r.mkind = '1;
    send_word(r);
    send_word(build_req(ttc_pkg::FUNC_PROBE, '1, 8'd255, 7'd127, 16'sd0));
    r = '0;
    send_word(r);
    send_word(build_req(ttc_pkg::FUNC_PROBE, 64'h0, 8'd0, 7'd0, 16'sd0));
    in_valid_i <= 1'b0;

    // Random phases: each with its own register setting and one of four idle and stall patterns
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: set_config(15'd32767, 8'd255, 16'sh8000);
        1: set_config(15'd0, 8'd0, 16'sh7FFF);
        2: set_config(15'd199, 8'h5A, 16'sd0);
        3: set_config(15'd200, 8'd1, -16'sd1);
        4: set_config(15'd32000, 8'd0, 16'sd0);
        6: set_config(15'd1000, 8'd128, 16'sd12345);
        default: set_config(15'($urandom), 8'($urandom), 16'($urandom));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (i = 0; i < PHASE_WORDS; i++) send_word(random_req());
      in_valid_i <= 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ttc_pkg.sv
hw/rtl/ttc_ram.sv
hw/rtl/ttc_cfg.sv
hw/rtl/ttc_eval.sv
hw/rtl/transposition_table_cluster_top.sv
verif/tb_top.sv
